### sv/rlar_pkg.sv
// ----------------------------------------------------------------------------
// Relocation log remapper package
// Shared types and constants for the relocation log address remapper and its
// entry cells.
// ----------------------------------------------------------------------------
package rlar_pkg;

	// Field widths of the stream beats.
	localparam int unsigned ADDR_W  = 48;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned ASIZE_W = 13;
	localparam int unsigned KIND_W  = 2;

	// Packed tdata widths, padded to whole bytes.
	localparam int unsigned S_TDATA_W = 192;
	localparam int unsigned M_TDATA_W = 56;

	// Default number of entries in the move log.
	localparam int unsigned LOG_DEPTH_DEF = 16;

	// Beat kinds carried on tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_LOG   = 2'd0,
		KIND_XLATE = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// One logged block move.
	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// Item travelling down the cell chain.
	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [ASIZE_W-1:0] size_m1;
		logic               fault;
		logic               full;
	} item_t;

endpackage

### sv/relocation_log_address_remapper.sv
// ----------------------------------------------------------------------------
// Relocation log address remapper
// Keeps an ordered log of block moves in a chain of entry cells and replays
// it over translate addresses, one cell per cycle while the result side does not stall.
// ----------------------------------------------------------------------------
// An accepted beat passes through the stage register of every cell to reach the result side.
// Throughput: one beat per cycle while the result side does not stall the cell chain.
// A log beat that follows a clear waits until the chain holds no older beats.
// Reset empties the log and the chain; logged entries are undefined until
// written. Back-pressure on the result side stalls the whole chain.
module relocation_log_address_remapper #(
	parameter int unsigned LOG_DEPTH = rlar_pkg::LOG_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// src_addr [47:0], dst_addr [95:48], block_size [127:96],
	// query_addr [175:128], access_size [188:176], zero [191:189]
	input  logic [rlar_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind [1:0]
	input  logic [rlar_pkg::KIND_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// mapped_addr [47:0], shear_fault [48], log_full [49], zero [55:50]
	output logic [rlar_pkg::M_TDATA_W-1:0]   m_tdata
);
	import rlar_pkg::*;

	localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);

	logic               en;
	logic               in_acc;
	logic               out_acc;
	kind_t              in_kind;
	logic [ADDR_W-1:0]  in_src;
	logic [ADDR_W-1:0]  in_dst;
	logic [LEN_W-1:0]   in_len;
	logic [ADDR_W-1:0]  in_query;
	logic [ASIZE_W-1:0] in_asize;
	logic               log_full;
	item_t              in_item;
	entry_t             wr_entry;

	logic [CNT_W-1:0]   entry_count_q;
	logic [CNT_W-1:0]   inflight_q;
	logic               stale_q;

	logic  [LOG_DEPTH:0] valid_c;
	item_t               item_c [LOG_DEPTH+1];
	logic  [CNT_W-1:0]   cnt_c  [LOG_DEPTH+1];

	// Unpack the input beat.
	assign in_kind  = kind_t'(s_tuser);
	assign in_src   = s_tdata[ADDR_W-1:0];
	assign in_dst   = s_tdata[2*ADDR_W-1:ADDR_W];
	assign in_len   = s_tdata[2*ADDR_W+LEN_W-1:2*ADDR_W];
	assign in_query = s_tdata[3*ADDR_W+LEN_W-1:2*ADDR_W+LEN_W];
	assign in_asize = s_tdata[3*ADDR_W+LEN_W+ASIZE_W-1:3*ADDR_W+LEN_W];

	// The chain moves whenever the output register is free or being drained.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en && !(stale_q && (in_kind == KIND_LOG));
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign log_full = (in_kind == KIND_LOG) && (entry_count_q >= CNT_W'(LOG_DEPTH));

	// Item entering the first cell; a zero access size counts as one byte.
	always_comb begin
		in_item         = '0;
		in_item.kind    = in_kind;
		in_item.addr    = in_query;
		in_item.size_m1 = (in_asize == '0) ? '0 : in_asize - ASIZE_W'(1);
		in_item.full    = log_full;
	end

	assign wr_entry = '{src: in_src, dst: in_dst, len: in_len};

	// Entry count: appends grow it, a clear empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (in_acc) begin
			unique case (in_kind)
				KIND_LOG: begin
					if (!log_full) begin
						entry_count_q <= entry_count_q + CNT_W'(1);
					end
				end
				KIND_CLEAR: entry_count_q <= '0;
				default:    entry_count_q <= entry_count_q;
			endcase
		end
	end

	// Beats in the chain, and a mark that older translates may still need
	// entries a new append would overwrite after a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			stale_q    <= 1'b0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
			if (in_acc && (in_kind == KIND_CLEAR)) begin
				stale_q <= 1'b1;
			end else if (inflight_q == '0) begin
				stale_q <= 1'b0;
			end
		end
	end

	assign valid_c[0] = in_acc;
	assign item_c[0]  = in_item;
	assign cnt_c[0]   = entry_count_q;

	// Chain of entry cells, oldest move first.
	for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
		logic wr_en;

		assign wr_en = in_acc && (in_kind == KIND_LOG) && !log_full &&
			(entry_count_q == CNT_W'(i));

		rlar_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.wr_en     (wr_en),
			.wr_entry  (wr_entry),
			.valid_in  (valid_c[i]),
			.item_in   (item_c[i]),
			.cnt_in    (cnt_c[i]),
			.valid_out (valid_c[i+1]),
			.item_out  (item_c[i+1]),
			.cnt_out   (cnt_c[i+1])
		);
	end

	// The last cell's stage register is the output register.
	assign m_tvalid = valid_c[LOG_DEPTH];
	assign m_tdata  = {
		{(M_TDATA_W-ADDR_W-2){1'b0}},
		item_c[LOG_DEPTH].full,
		item_c[LOG_DEPTH].fault,
		(item_c[LOG_DEPTH].kind == KIND_XLATE) ? item_c[LOG_DEPTH].addr : {ADDR_W{1'b0}}
	};

`ifndef ASSERT_OFF
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(LOG_DEPTH))
		else $error("more beats in flight than cells");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(LOG_DEPTH))
		else $error("entry count beyond log depth");

	a_valid_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (inflight_q != '0))
		else $error("result beat with nothing in flight");

	a_no_log_when_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(stale_q && s_tvalid && (in_kind == KIND_LOG)) |-> !s_tready)
		else $error("append accepted while older translates may read its cell");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[ADDR_W] && m_tdata[ADDR_W+1]))
		else $error("shear and full flagged on one beat");
`endif

endmodule

### sv/rlar_cell.sv
// ----------------------------------------------------------------------------
// Relocation log entry cell
// Holds one logged move and applies it to the item passing through, then
// registers the item for the next cell in the chain.
// ----------------------------------------------------------------------------
module rlar_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                wr_en,
	input  rlar_pkg::entry_t    wr_entry,
	input  logic                valid_in,
	input  rlar_pkg::item_t     item_in,
	input  logic [CNT_W-1:0]    cnt_in,
	output logic                valid_out,
	output rlar_pkg::item_t     item_out,
	output logic [CNT_W-1:0]    cnt_out
);
	import rlar_pkg::*;

	entry_t             entry_q;
	logic               valid_s1;
	item_t              item_s1;
	logic [CNT_W-1:0]   cnt_s1;

	logic               active;
	logic [ADDR_W:0]    diff;
	logic [ADDR_W-1:0]  off;
	logic [ADDR_W-1:0]  len_ext;
	logic [ADDR_W:0]    last_off;
	logic               hit;
	item_t              item_nxt;

	// Entry storage, written once per append.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end
	end

	// The entry only takes part for translates that were issued after it was logged.
	assign active   = (item_in.kind == KIND_XLATE) && (CNT_W'(IDX) < cnt_in);
	assign diff     = {1'b0, item_in.addr} - {1'b0, entry_q.src};
	assign off      = diff[ADDR_W-1:0];
	assign len_ext  = {{(ADDR_W-LEN_W){1'b0}}, entry_q.len};
	assign last_off = {1'b0, off} + {{(ADDR_W+1-ASIZE_W){1'b0}}, item_in.size_m1};
	assign hit      = active && !diff[ADDR_W] && (off < len_ext);

	// Rebase on a hit and flag a shear when the last byte leaves the block.
	always_comb begin
		item_nxt = item_in;
		if (hit) begin
			item_nxt.addr = entry_q.dst + off;
			if (last_off >= {1'b0, len_ext}) begin
				item_nxt.fault = 1'b1;
			end
		end
	end

	// Stage register towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_nxt;
			cnt_s1  <= cnt_in;
		end
	end

	assign valid_out = valid_s1;
	assign item_out  = item_s1;
	assign cnt_out   = cnt_s1;

endmodule
